### sv/gmba_pkg.sv
// Shared types and constants for the grouped max-by aggregate block.
// Beat structs for the input and result queues, and the front-to-back op.
// No dependencies.
package gmba_pkg;

  localparam int GROUP_COUNT_DEF = 1024;
  localparam int KEY_BITS_DEF    = 64;
  localparam int VALUE_BITS_DEF  = 64;
  localparam int FIELD_W         = 64;
  localparam int GROUP_W         = 10;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    KIND_RAW     = 2'd0,
    KIND_MERGE   = 2'd1,
    KIND_INIT    = 2'd2,
    KIND_EXTRACT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [GROUP_W-1:0]        group;
    logic signed [FIELD_W-1:0] sort_key;
    logic                      key_is_null;
    logic signed [FIELD_W-1:0] target_value;
    logic                      target_is_null;
    logic                      batch_last;
  } in_item_t;

  typedef struct packed {
    logic [GROUP_W-1:0]        out_group;
    logic signed [FIELD_W-1:0] out_target;
    logic                      out_target_null;
    logic signed [FIELD_W-1:0] out_key;
    logic                      out_key_null;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_UPDATE       = 2'd0,
    OP_INIT         = 2'd1,
    OP_EXTRACT      = 2'd2,
    OP_EXTRACT_NONE = 2'd3
  } op_code_t;

  typedef struct packed {
    op_code_t                  code;
    logic [GROUP_W-1:0]        group;
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] target;
    logic                      target_null;
  } op_t;

endpackage

### sv/gmba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gmba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/gmba_front.sv
// Front end: accepts input beats, drops no-op rows, trims key/target widths
// and queues the resulting ops for the back end. Depends on gmba_pkg.
module gmba_front import gmba_pkg::*; #(
  parameter int GROUP_COUNT = GROUP_COUNT_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  input  logic     q_pop,
  output logic     q_empty,
  output op_t      q_head
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic                        in_ok;
  logic                        keep;
  logic signed [KEY_BITS-1:0]  key_trim;
  logic signed [VALUE_BITS-1:0] tgt_trim;
  op_t                         op;
  logic                        push_en;

  op_t            q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    in_ok          = (32'(in_item.group) < GROUP_COUNT);
    key_trim       = in_item.sort_key[KEY_BITS-1:0];
    tgt_trim       = in_item.target_value[VALUE_BITS-1:0];
    op.group       = in_item.group;
    op.key         = FIELD_W'(key_trim);
    op.target      = FIELD_W'(tgt_trim);
    op.target_null = in_item.target_is_null;
    op.code        = OP_UPDATE;
    keep           = 1'b0;
    case (in_item.kind)
      KIND_EXTRACT: begin
        keep    = 1'b1;
        op.code = in_ok ? OP_EXTRACT : OP_EXTRACT_NONE;
      end
      KIND_INIT: begin
        keep    = in_ok;
        op.code = OP_INIT;
      end
      KIND_RAW: begin
        keep = in_ok && !in_item.key_is_null;
      end
      KIND_MERGE: begin
        keep = in_ok && !in_item.key_is_null && !in_item.target_is_null;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_full = (count_r == QCW'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = q_r[rd_ptr_r];
  assign push_en = in_push && !in_full && keep;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop && !q_empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_en && !(q_pop && !q_empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_en && q_pop && !q_empty) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_r[wr_ptr_r] <= op;
    end
  end

endmodule

### sv/gmba_back.sv
// Back end: per-op read-modify-write of the group state RAM, result register
// and the output_partial config register. Depends on gmba_pkg, gmba_ram.
module gmba_back import gmba_pkg::*; #(
  parameter int GROUP_COUNT = GROUP_COUNT_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  op_t       q_head,
  output logic      q_pop,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  localparam int AW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int REC_W = KEY_BITS + VALUE_BITS + 2;
  localparam logic [KEY_BITS-1:0] KEY_MIN = ~({KEY_BITS{1'b1}} >> 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  op_t       op_r, op_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      partial_r, partial_nxt;

  logic                         ram_we;
  logic                         ram_re;
  logic [REC_W-1:0]             ram_wdata;
  logic [REC_W-1:0]             ram_rdata;
  logic signed [KEY_BITS-1:0]   rec_key;
  logic signed [VALUE_BITS-1:0] rec_tgt;
  logic                         rec_empty;
  logic                         rec_tnull;
  logic signed [KEY_BITS-1:0]   op_key;
  logic [VALUE_BITS-1:0]        op_tgt;
  logic                         is_extract;
  logic                         done;
  logic                         take;

  gmba_ram #(
    .WIDTH (REC_W),
    .DEPTH (GROUP_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(op_r.group)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(q_head.group)),
    .rdata (ram_rdata)
  );

  always_comb begin
    rec_key    = ram_rdata[REC_W-1 -: KEY_BITS];
    rec_tgt    = ram_rdata[VALUE_BITS+1:2];
    rec_empty  = ram_rdata[1];
    rec_tnull  = ram_rdata[0];
    op_key     = op_r.key[KEY_BITS-1:0];
    op_tgt     = op_r.target[VALUE_BITS-1:0];
    is_extract = (op_r.code == OP_EXTRACT) || (op_r.code == OP_EXTRACT_NONE);
    done       = !is_extract || !out_valid_r || out_pop;
    take       = (op_key >= rec_key);
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    partial_nxt   = cfg_we ? cfg_wdata : partial_r;
    q_pop         = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = ram_rdata;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          op_nxt    = q_head;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_nxt = ST_IDLE;
          case (op_r.code)
            OP_UPDATE: begin
              ram_we    = take;
              ram_wdata = {op_key, op_r.target_null ? rec_tgt : op_tgt,
                           1'b0, op_r.target_null};
            end
            OP_INIT: begin
              ram_we    = 1'b1;
              ram_wdata = {KEY_MIN, rec_tgt, 1'b1, 1'b0};
            end
            OP_EXTRACT: begin
              out_valid_nxt           = 1'b1;
              out_nxt.out_group       = op_r.group;
              out_nxt.out_target_null = rec_empty || rec_tnull;
              out_nxt.out_target      = (rec_empty || rec_tnull) ? '0 : FIELD_W'(rec_tgt);
              out_nxt.out_key_null    = rec_empty || !partial_r;
              out_nxt.out_key         = (rec_empty || !partial_r) ? '0 : FIELD_W'(rec_key);
            end
            OP_EXTRACT_NONE: begin
              out_valid_nxt           = 1'b1;
              out_nxt.out_group       = op_r.group;
              out_nxt.out_target_null = 1'b1;
              out_nxt.out_target      = '0;
              out_nxt.out_key_null    = 1'b1;
              out_nxt.out_key         = '0;
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      partial_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      partial_r   <= partial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

### sv/grouped_max_by_aggregate_top.sv
// Top level of the grouped max-by aggregate block.
// Depends on gmba_pkg, gmba_front, gmba_back (and gmba_ram below it).
//
// Keeps a max-by state per group in one RAM of GROUP_COUNT entries. The
// front takes one input beat per cycle into a 4-entry op queue while the
// queue is not full, dropping rows that change nothing. The back runs each
// queued op as a RAM read followed by a compare and write-back, and takes
// no new op until it is through with the last; that read-modify-write loop
// on the single state RAM sets the sustained rate. An extract beat passes
// the op queue, the back's op register and the result register on its way
// to the result port. There is no clearing pass after reset:
// every group must see an init beat before rows or extracts address it.
module grouped_max_by_aggregate_top import gmba_pkg::*; #(
  parameter int GROUP_COUNT = GROUP_COUNT_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic q_pop;
  logic q_empty;
  op_t  q_head;

  gmba_front #(
    .GROUP_COUNT (GROUP_COUNT),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  gmba_back #(
    .GROUP_COUNT (GROUP_COUNT),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### verif/grouped_max_by_aggregate_top_test.sv
`timescale 1ns / 100ps
// Self-checking test for grouped_max_by_aggregate_top: directed and random beats are checked
// against a per-group max-by predictor, with random idle on both queues and both output modes.
// Depends on gmba_pkg and the grouped_max_by_aggregate_top RTL.
module grouped_max_by_aggregate_top_test;
  import gmba_pkg::*;

  localparam int SETTLE_CYCLES = 32;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  // per-group max-by state
  logic signed [FIELD_W-1:0] grp_key    [GROUP_COUNT_DEF];
  logic signed [FIELD_W-1:0] grp_target [GROUP_COUNT_DEF];
  bit                        grp_empty  [GROUP_COUNT_DEF];
  bit                        grp_tnull  [GROUP_COUNT_DEF];
  bit                        grp_live   [GROUP_COUNT_DEF];
  int                        live_groups [$];
  bit                        partial_mode = 1'b0;
  out_item_t                 pending_extracts [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int mode_writes = 0;

  grouped_max_by_aggregate_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void apply_beat(input in_item_t beat);
    out_item_t res;
    int g;
    g = int'(beat.group);
    case (beat.kind)
      KIND_INIT: begin
        grp_empty[g] = 1'b1;
        grp_tnull[g] = 1'b0;
        grp_key[g] = FIELD_MIN;
        if (!grp_live[g]) begin
          grp_live[g] = 1'b1;
          live_groups.push_back(g);
        end
      end
      KIND_EXTRACT: begin
        res = '0;
        res.out_group = beat.group;
        res.out_target_null = 1'b1;
        res.out_key_null = 1'b1;
        if (!grp_empty[g]) begin
          if (!grp_tnull[g]) begin
            res.out_target = grp_target[g];
            res.out_target_null = 1'b0;
          end
          if (partial_mode) begin
            res.out_key = grp_key[g];
            res.out_key_null = 1'b0;
          end
        end
        pending_extracts.push_back(res);
      end
      default: begin
        // later row wins on equal keys
        if (!beat.key_is_null && !(beat.kind == KIND_MERGE && beat.target_is_null) &&
            $signed(beat.sort_key) >= grp_key[g]) begin
          grp_empty[g] = 1'b0;
          grp_key[g] = beat.sort_key;
          grp_tnull[g] = beat.target_is_null;
          if (!beat.target_is_null) grp_target[g] = beat.target_value;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [FIELD_W-1:0] exp_v,
                                      input logic [FIELD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (pending_extracts.size() == 0) begin
        errors++;
        $display("%0t: result beat with no extract waiting, expected none actual %h",
                 $time, out_item);
      end else begin
        exp_r = pending_extracts.pop_front();
        check_field("out_group", FIELD_W'(exp_r.out_group), FIELD_W'(out_item.out_group));
        check_field("out_target", exp_r.out_target, out_item.out_target);
        check_field("out_target_null", FIELD_W'(exp_r.out_target_null),
                    FIELD_W'(out_item.out_target_null));
        check_field("out_key", exp_r.out_key, out_item.out_key);
        check_field("out_key_null", FIELD_W'(exp_r.out_key_null),
                    FIELD_W'(out_item.out_key_null));
      end
    end
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic signed [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_key();
    logic signed [FIELD_W-1:0] k;
    case ($urandom_range(7))
      0: k = FIELD_MIN;
      1: k = FIELD_MAX;
      2, 3: begin
        // narrow range so equal keys are common
        k = FIELD_W'($urandom_range(6));
        k -= 3;
      end
      default: k = rand_word();
    endcase
    return k;
  endfunction

  function automatic in_item_t make_beat(input kind_t kind, input int group,
                                         input logic signed [FIELD_W-1:0] key, input bit key_null,
                                         input logic signed [FIELD_W-1:0] target,
                                         input bit target_null, input bit last);
    in_item_t b;
    b.kind = kind;
    b.group = GROUP_W'(group);
    b.sort_key = key;
    b.key_is_null = key_null;
    b.target_value = target;
    b.target_is_null = target_null;
    b.batch_last = last;
    return b;
  endfunction

  function automatic in_item_t random_beat(input kind_t kind, input int group);
    return make_beat(kind, group, rand_word(), 1'($urandom_range(1)), rand_word(),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  function automatic in_item_t random_row(input int group);
    kind_t kind;
    kind = $urandom_range(1) ? KIND_RAW : KIND_MERGE;
    return make_beat(kind, group, pick_key(), $urandom_range(7) == 0, rand_word(),
                     $urandom_range(5) == 0, 1'($urandom_range(1)));
  endfunction

  function automatic int pick_live();
    return live_groups[$urandom_range(live_groups.size() - 1)];
  endfunction

  function automatic int pick_init_group();
    return ($urandom_range(3) == 0) ? $urandom_range(GROUP_COUNT_DEF - 1) : $urandom_range(15);
  endfunction

  task automatic send_beat(input in_item_t beat);
    while ($urandom_range(99) < gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (in_full);
    apply_beat(beat);
    beats_sent++;
  endtask

  task automatic send_counted(input in_item_t beat, inout int done);
    send_beat(beat);
    done++;
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (pending_extracts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit partial);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= partial;
    @(posedge clk);
    cfg_we <= 1'b0;
    partial_mode = partial;
    mode_writes++;
  endtask

  task automatic test_empty_and_extremes();
    send_beat(random_beat(KIND_INIT, 0));
    send_beat(random_beat(KIND_EXTRACT, 0));
    send_beat(random_beat(KIND_INIT, GROUP_COUNT_DEF - 1));
    send_beat(make_beat(KIND_RAW, GROUP_COUNT_DEF - 1, FIELD_MIN, 0, FIELD_MAX, 0, 0));
    send_beat(random_beat(KIND_EXTRACT, GROUP_COUNT_DEF - 1));
    send_beat(make_beat(KIND_RAW, GROUP_COUNT_DEF - 1, FIELD_MIN, 0, -1, 0, 1));
    send_beat(make_beat(KIND_RAW, GROUP_COUNT_DEF - 1, FIELD_MAX, 1, 5, 0, 0));
    send_beat(make_beat(KIND_MERGE, GROUP_COUNT_DEF - 1, FIELD_MAX, 0, 9, 1, 1));
    send_beat(random_beat(KIND_EXTRACT, GROUP_COUNT_DEF - 1));
  endtask

  task automatic test_ties_and_nulls();
    send_beat(make_beat(KIND_RAW, 0, FIELD_MAX, 0, 3, 1, 0));
    send_beat(random_beat(KIND_EXTRACT, 0));
    send_beat(make_beat(KIND_MERGE, 0, FIELD_MAX, 0, 42, 0, 0));
    send_beat(make_beat(KIND_RAW, 0, 0, 0, 7, 0, 1));
    send_beat(random_beat(KIND_EXTRACT, 0));
    send_beat(random_beat(KIND_INIT, 0));
    send_beat(random_beat(KIND_EXTRACT, 0));
  endtask

  task automatic test_partial_mode();
    write_mode(1'b1);
    send_beat(make_beat(KIND_RAW, GROUP_COUNT_DEF - 1, FIELD_MAX, 0, FIELD_MIN, 0, 0));
    send_beat(random_beat(KIND_EXTRACT, GROUP_COUNT_DEF - 1));
    send_beat(random_beat(KIND_EXTRACT, 0));
    send_beat(make_beat(KIND_RAW, 0, FIELD_MIN, 0, 11, 1, 1));
    send_beat(random_beat(KIND_EXTRACT, 0));
    send_beat(make_beat(KIND_MERGE, 0, FIELD_MIN, 0, FIELD_MAX, 0, 0));
    send_beat(random_beat(KIND_EXTRACT, 0));
  endtask

  task automatic run_random(input int count);
    int done;
    int g;
    int rows;
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 75) begin
        // init (or reuse a live group), a few rows, then extract
        if ($urandom_range(1)) begin
          g = pick_live();
        end else begin
          g = pick_init_group();
          send_counted(random_beat(KIND_INIT, g), done);
        end
        rows = $urandom_range(6);
        repeat (rows) send_counted(random_row(g), done);
        send_counted(random_beat(KIND_EXTRACT, g), done);
      end else begin
        case ($urandom_range(3))
          0: send_counted(random_beat(KIND_INIT, pick_init_group()), done);
          1: send_counted(random_row(pick_live()), done);
          default: send_counted(random_beat(KIND_EXTRACT, pick_live()), done);
        endcase
      end
    end
  endtask

  task automatic test_random_phase(input int sender_gap, input int pop_stall, input bit first_mode);
    gap_pct = sender_gap;
    stall_pct = pop_stall;
    for (int i = 0; i < 3; i++) begin
      write_mode(first_mode ^ i[0]);
      run_random(106);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);
    test_empty_and_extremes();
    test_ties_and_nulls();
    test_partial_mode();
    test_random_phase(30, 64, 1'b0);
    test_random_phase(64, 30, 1'b1);
    test_random_phase(0, 0, 1'b0);
    settle();
    $display("Sent %0d beats across %0d output-mode writes; checked %0d extract results.",
             beats_sent, mode_writes, results_checked);
    $display("Covered empty, tied and null groups in final and partial modes under stalls.");
    if (errors == 0) begin
      $display("grouped_max_by_aggregate_top test passed");
    end else begin
      $display("grouped_max_by_aggregate_top test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("grouped_max_by_aggregate_top test failed");
    $finish;
  end

endmodule

### sim.f
sv/gmba_pkg.sv
sv/gmba_ram.sv
sv/gmba_front.sv
sv/gmba_back.sv
sv/grouped_max_by_aggregate_top.sv
verif/grouped_max_by_aggregate_top_test.sv
